// File: hdl/qvi_pkg.sv
// package for the qr version-information decoder
// holds the item structs, status codes, codeword table and distance helpers; no dependencies
package qvi_pkg;

   localparam int CODE_COUNT          = 34;
   localparam int VER_W               = 6;
   localparam int WORD_W              = 18;
   localparam int SIZE_W              = 8;
   localparam int DIST_W              = 3;
   localparam int IDX_W               = 6;
   localparam int TREE_LEAVES         = 64;
   localparam int TREE_LEVELS         = 6;

   localparam logic [VER_W-1:0]  FIRST_CODED_VERSION = 6'd7;
   localparam logic [DIST_W-1:0] MAX_CORRECTABLE     = 3'd3;
   localparam logic [DIST_W-1:0] DIST_NONE           = 3'd4;
   localparam logic [SIZE_W-1:0] MIN_SIZE            = 8'd21;
   localparam logic [SIZE_W-1:0] MAX_SIZE            = 8'd177;
   localparam logic [SIZE_W-1:0] SMALL_LIMIT         = 8'd45;
   localparam logic [SIZE_W-1:0] SIZE_OFFSET         = 8'd17;
   localparam logic [1:0]        SIZE_RESIDUE        = 2'b01;

   // bch(18,6) codewords for versions 7 to 40
   localparam logic [WORD_W-1:0] VER_CODES [CODE_COUNT] = '{
      18'h07C94, 18'h085BC, 18'h09A99, 18'h0A4D3, 18'h0BBF6, 18'h0C762, 18'h0D847,
      18'h0E60D, 18'h0F928, 18'h10B78, 18'h1145D, 18'h12A17, 18'h13532, 18'h149A6,
      18'h15683, 18'h168C9, 18'h177EC, 18'h18EC4, 18'h191E1, 18'h1AFAB, 18'h1B08E,
      18'h1CC1A, 18'h1D33F, 18'h1ED75, 18'h1F250, 18'h209D5, 18'h216F0, 18'h228BA,
      18'h2379F, 18'h24B0B, 18'h2542E, 18'h26A64, 18'h27541, 18'h28C69
   };

   typedef enum logic [1:0] {
      STATUS_BAD_SIZE      = 2'd0,
      STATUS_OK            = 2'd1,
      STATUS_UNCORRECTABLE = 2'd2,
      STATUS_MISMATCH      = 2'd3
   } status_type;

   typedef struct packed {
      logic [SIZE_W-1:0] sym_width;
      logic [SIZE_W-1:0] sym_height;
      logic [WORD_W-1:0] lower_left_word;
      logic [WORD_W-1:0] upper_right_word;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [VER_W-1:0] version;
   } rsp_type;

   typedef struct packed {
      logic             size_ok;
      logic             small_sym;
      logic [VER_W-1:0] size_ver;
   } size_info_type;

   // bit count of an 18-bit word, clipped to DIST_NONE above the correctable limit
   function automatic logic [DIST_W-1:0] dist_sat(input logic [WORD_W-1:0] x);
      logic [4:0] total;
      logic [1:0] grp;
      int         g;
      total = '0;
      for (g = 0; g < WORD_W / 3; g++) begin
         grp   = 2'(x[3*g]) + 2'(x[3*g+1]) + 2'(x[3*g+2]);
         total = total + 5'(grp);
      end
      return (total > 5'(MAX_CORRECTABLE)) ? DIST_NONE : DIST_W'(total);
   endfunction

endpackage

// File: hdl/qvi_dist_stage.sv
// distance stage: size checks and per-codeword distance of both words, registered
// depends on qvi_pkg
module qvi_dist_stage (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            in_valid,
   input  qvi_pkg::req_type                                in_item,
   output logic                                            out_valid,
   output qvi_pkg::size_info_type                          out_info,
   output logic [qvi_pkg::CODE_COUNT-1:0][qvi_pkg::DIST_W-1:0] out_dist
);

   logic                                                valid_ff;
   qvi_pkg::size_info_type                              info_ff, info_in;
   logic [qvi_pkg::CODE_COUNT-1:0][qvi_pkg::DIST_W-1:0] dist_ff, dist_in;

   always_comb begin
      logic [qvi_pkg::SIZE_W-1:0] w;
      logic [qvi_pkg::SIZE_W-1:0] h;
      logic [qvi_pkg::SIZE_W-1:0] off;
      w   = in_item.sym_width;
      h   = in_item.sym_height;
      off = w - qvi_pkg::SIZE_OFFSET;
      info_in.size_ok   = (w == h) && (w >= qvi_pkg::MIN_SIZE) && (w <= qvi_pkg::MAX_SIZE)
                          && (w[1:0] == qvi_pkg::SIZE_RESIDUE);
      info_in.small_sym = (w < qvi_pkg::SMALL_LIMIT);
      info_in.size_ver  = off[qvi_pkg::VER_W+1:2];
   end

   // both words against every codeword, keep the nearer one per entry
   always_comb begin
      logic [qvi_pkg::DIST_W-1:0] dl;
      logic [qvi_pkg::DIST_W-1:0] du;
      int                         i;
      for (i = 0; i < qvi_pkg::CODE_COUNT; i++) begin
         dl = qvi_pkg::dist_sat(in_item.lower_left_word ^ qvi_pkg::VER_CODES[i]);
         du = qvi_pkg::dist_sat(in_item.upper_right_word ^ qvi_pkg::VER_CODES[i]);
         dist_in[i] = (du < dl) ? du : dl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      info_ff <= info_in;
      dist_ff <= dist_in;
   end

   assign out_valid = valid_ff;
   assign out_info  = info_ff;
   assign out_dist  = dist_ff;

endmodule

// File: hdl/qvi_select_stage.sv
// select stage: nearest-codeword tree, status decision and result register
// depends on qvi_pkg
module qvi_select_stage (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            in_valid,
   input  qvi_pkg::size_info_type                          in_info,
   input  logic [qvi_pkg::CODE_COUNT-1:0][qvi_pkg::DIST_W-1:0] in_dist,
   output logic                                            out_valid,
   output qvi_pkg::rsp_type                                out_item
);

   logic                       valid_ff;
   qvi_pkg::rsp_type           rsp_ff, rsp_in;
   logic [qvi_pkg::DIST_W-1:0] best_dist;
   logic [qvi_pkg::IDX_W-1:0]  best_idx;

   // pairwise min tree, left entry wins ties
   always_comb begin
      logic [qvi_pkg::DIST_W-1:0] nd [qvi_pkg::TREE_LEAVES];
      logic [qvi_pkg::IDX_W-1:0]  ni [qvi_pkg::TREE_LEAVES];
      int                         i;
      int                         lvl;
      int                         j;
      for (i = 0; i < qvi_pkg::CODE_COUNT; i++) begin
         nd[i] = in_dist[i];
         ni[i] = qvi_pkg::IDX_W'(i);
      end
      // padding leaves never win against a real entry
      for (i = qvi_pkg::CODE_COUNT; i < qvi_pkg::TREE_LEAVES; i++) begin
         nd[i] = qvi_pkg::DIST_NONE;
         ni[i] = qvi_pkg::IDX_W'(i);
      end
      for (lvl = 0; lvl < qvi_pkg::TREE_LEVELS; lvl++) begin
         for (j = 0; j < (qvi_pkg::TREE_LEAVES >> (lvl + 1)); j++) begin
            if (nd[2*j+1] < nd[2*j]) begin
               nd[j] = nd[2*j+1];
               ni[j] = ni[2*j+1];
            end else begin
               nd[j] = nd[2*j];
               ni[j] = ni[2*j];
            end
         end
      end
      best_dist = nd[0];
      best_idx  = ni[0];
   end

   always_comb begin
      logic [qvi_pkg::VER_W-1:0] best_ver;
      best_ver = best_idx + qvi_pkg::FIRST_CODED_VERSION;
      if (!in_info.size_ok) begin
         rsp_in.status  = qvi_pkg::STATUS_BAD_SIZE;
         rsp_in.version = '0;
      end else if (in_info.small_sym) begin
         rsp_in.status  = qvi_pkg::STATUS_OK;
         rsp_in.version = in_info.size_ver;
      end else if (best_dist > qvi_pkg::MAX_CORRECTABLE) begin
         rsp_in.status  = qvi_pkg::STATUS_UNCORRECTABLE;
         rsp_in.version = in_info.size_ver;
      end else if (best_ver != in_info.size_ver) begin
         rsp_in.status  = qvi_pkg::STATUS_MISMATCH;
         rsp_in.version = best_ver;
      end else begin
         rsp_in.status  = qvi_pkg::STATUS_OK;
         rsp_in.version = in_info.size_ver;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = rsp_ff;

endmodule

// File: hdl/qr_version_info_decode_unit.sv
// top level of the qr version-information decoder
// depends on qvi_pkg, qvi_dist_stage and qvi_select_stage
//
// Decodes the version of a QR symbol from its size and the two 18-bit
// version-information words. One item is taken on every cycle with start
// high; busy never rises, because a fresh item enters the three-stage
// pipeline (input register, distance register, result register) every
// cycle. The result appears on rsp_item with rsp_valid high for exactly one
// cycle, three cycles after the item was taken, and the receiver cannot
// hold it off, so it must capture it on that cycle. Results come out in
// the order items went in. Status codes: bad size (version 0), ok with the
// size-derived version, uncorrectable (size-derived version kept), and
// mismatch (carrying the version decoded from the words).
module qr_version_info_decode_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  qvi_pkg::req_type req_item,
   output logic             rsp_valid,
   output qvi_pkg::rsp_type rsp_item
);

   logic                                                req_valid_ff;
   qvi_pkg::req_type                                    req_ff;
   logic                                                accept;
   logic                                                dist_valid;
   qvi_pkg::size_info_type                              dist_info;
   logic [qvi_pkg::CODE_COUNT-1:0][qvi_pkg::DIST_W-1:0] dist_vals;

   // never stalls: every cycle can take a new item
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
   end

   // size checks and distance of both words to every codeword
   qvi_dist_stage u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid_ff),
      .in_item   (req_ff),
      .out_valid (dist_valid),
      .out_info  (dist_info),
      .out_dist  (dist_vals)
   );

   // nearest codeword and final status
   qvi_select_stage u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dist_valid),
      .in_info   (dist_info),
      .in_dist   (dist_vals),
      .out_valid (rsp_valid),
      .out_item  (rsp_item)
   );

   // every taken item shows up as a result once it has passed the three registers
   a_latency_in : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_valid)
      else $error("item taken but no result after three cycles");

   // no result without an item taken earlier through the three registers
   a_latency_out : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 3))
      else $error("result strobe without a matching item");

   // a bad size always reports version zero
   a_bad_size_ver : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == qvi_pkg::STATUS_BAD_SIZE) |-> (rsp_item.version == '0))
      else $error("bad size with nonzero version");

   // a mismatch carries a coded version, 7 to 40
   a_mismatch_ver : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == qvi_pkg::STATUS_MISMATCH) |->
      (rsp_item.version >= qvi_pkg::FIRST_CODED_VERSION && rsp_item.version <= 6'd40))
      else $error("mismatch version out of coded range");

   // good sizes give versions 1 to 40
   a_size_ver : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status == qvi_pkg::STATUS_OK ||
                     rsp_item.status == qvi_pkg::STATUS_UNCORRECTABLE)) |->
      (rsp_item.version >= 6'd1 && rsp_item.version <= 6'd40))
      else $error("size-derived version out of range");

endmodule

// File: verif/qvi_decode_checker.sv
// checker for the qr version-information decoder: watches the item and result
// channels, predicts each result from the accepted item and compares them in order
// depends on qvi_pkg for the item structs and the status codes
module qvi_decode_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  qvi_pkg::req_type req_item,
   input  logic             rsp_valid,
   input  qvi_pkg::rsp_type rsp_item,
   output int               fail_count,
   output int               pending,
   output int               bad_size_hits,
   output int               ok_hits,
   output int               uncorrectable_hits,
   output int               disagree_hits
);
   timeunit 1ns;
   timeprecision 1ps;
   import qvi_pkg::*;

   localparam int         NUM_CODEWORDS = 34;
   localparam int         FIRST_VERSION = 7;
   localparam int         MAX_FIXABLE   = 3;
   localparam int         SIZE_LO       = 21;
   localparam int         SIZE_HI       = 177;
   localparam int         SMALL_BELOW   = 45;
   localparam int         SIZE_BIAS     = 17;
   localparam logic [1:0] SIZE_MOD4     = 2'b01;

   rsp_type expected_results [$];
   rsp_type want;
   int      errors = 0;
   int      result_index = 0;
   int      n_bad = 0;
   int      n_ok = 0;
   int      n_uncorr = 0;
   int      n_disagree = 0;

   // valid version codewords, versions 7 to 40
   function automatic logic [17:0] codeword_of(input int idx);
      case (idx)
         0:  return 18'h07C94;  1: return 18'h085BC;  2: return 18'h09A99;
         3:  return 18'h0A4D3;  4: return 18'h0BBF6;  5: return 18'h0C762;
         6:  return 18'h0D847;  7: return 18'h0E60D;  8: return 18'h0F928;
         9:  return 18'h10B78; 10: return 18'h1145D; 11: return 18'h12A17;
         12: return 18'h13532; 13: return 18'h149A6; 14: return 18'h15683;
         15: return 18'h168C9; 16: return 18'h177EC; 17: return 18'h18EC4;
         18: return 18'h191E1; 19: return 18'h1AFAB; 20: return 18'h1B08E;
         21: return 18'h1CC1A; 22: return 18'h1D33F; 23: return 18'h1ED75;
         24: return 18'h1F250; 25: return 18'h209D5; 26: return 18'h216F0;
         27: return 18'h228BA; 28: return 18'h2379F; 29: return 18'h24B0B;
         30: return 18'h2542E; 31: return 18'h26A64; 32: return 18'h27541;
         33: return 18'h28C69;
         default: return 18'h00000;
      endcase
   endfunction

   function automatic rsp_type decode_version(input req_type it);
      rsp_type    res;
      logic [7:0] w;
      logic [7:0] h;
      logic [5:0] size_ver;
      logic [5:0] best_ver;
      int         best_dist;
      int         d_ll;
      int         d_ur;
      int         i;
      w          = it.sym_width;
      h          = it.sym_height;
      res.status  = STATUS_BAD_SIZE;
      res.version = '0;
      best_dist   = 32;
      best_ver    = '0;
      if (w != h || int'(w) < SIZE_LO || int'(w) > SIZE_HI || w[1:0] != SIZE_MOD4)
         return res;
      size_ver    = 6'((int'(w) - SIZE_BIAS) / 4);
      res.status  = STATUS_OK;
      res.version = size_ver;
      if (int'(w) < SMALL_BELOW)
         return res;
      // nearest codeword, first entry wins ties, bottom-left word tried first
      for (i = 0; i < NUM_CODEWORDS; i++) begin
         d_ll = $countones(it.lower_left_word ^ codeword_of(i));
         d_ur = $countones(it.upper_right_word ^ codeword_of(i));
         if (d_ll < best_dist) begin
            best_dist = d_ll;
            best_ver  = 6'(i + FIRST_VERSION);
         end
         if (d_ur < best_dist) begin
            best_dist = d_ur;
            best_ver  = 6'(i + FIRST_VERSION);
         end
      end
      if (best_dist > MAX_FIXABLE) begin
         res.status = STATUS_UNCORRECTABLE;
      end else if (best_ver != size_ver) begin
         res.status  = STATUS_MISMATCH;
         res.version = best_ver;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int exp_val);
      $display("[%0t] result %0d: %s is %0d, predicted %0d",
               $realtime, result_index, what, got, exp_val);
      errors++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               report_mismatch("status of a result with no item waiting",
                               int'(rsp_item.status), -1);
            end else begin
               want = expected_results.pop_front();
               if (rsp_item.status != want.status)
                  report_mismatch("status", int'(rsp_item.status), int'(want.status));
               if (rsp_item.version != want.version)
                  report_mismatch("version", int'(rsp_item.version), int'(want.version));
               case (want.status)
                  STATUS_BAD_SIZE:      n_bad++;
                  STATUS_OK:            n_ok++;
                  STATUS_UNCORRECTABLE: n_uncorr++;
                  default:              n_disagree++;
               endcase
            end
            result_index++;
         end
         if (start && !busy)
            expected_results.push_back(decode_version(req_item));
      end
      fail_count         <= errors;
      pending            <= expected_results.size();
      bad_size_hits      <= n_bad;
      ok_hits            <= n_ok;
      uncorrectable_hits <= n_uncorr;
      disagree_hits      <= n_disagree;
   end

endmodule

// File: verif/qr_version_info_decode_unit_tb.sv
// testbench top for the qr version-information decoder: drives directed and
// random items in bursts and gives the verdict from the checker's counts
// depends on qvi_pkg, qvi_decode_checker and qr_version_info_decode_unit
module qr_version_info_decode_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import qvi_pkg::*;

   localparam int          RANDOM_ITEMS = 1850;
   localparam int          DRAIN_LIMIT  = 200;
   localparam int          TAIL_CYCLES  = 8;
   localparam logic [12:0] BCH_POLY     = 13'h1F25;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   int fail_count;
   int pending;
   int bad_size_hits;
   int ok_hits;
   int uncorrectable_hits;
   int disagree_hits;
   int items_sent = 0;

   qr_version_info_decode_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   qvi_decode_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_item           (req_item),
      .rsp_valid          (rsp_valid),
      .rsp_item           (rsp_item),
      .fail_count         (fail_count),
      .pending            (pending),
      .bad_size_hits      (bad_size_hits),
      .ok_hits            (ok_hits),
      .uncorrectable_hits (uncorrectable_hits),
      .disagree_hits      (disagree_hits)
   );

   // 20 ns clock
   initial begin
      forever #10 clock = ~clock;
   end

   // hard stop in case the pipeline hangs
   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // version word built by polynomial division, independent of the checker's table
   function automatic logic [17:0] bch_word(input int ver);
      logic [17:0] rem;
      int          b;
      rem = 18'(ver) << 12;
      for (b = 17; b >= 12; b--) begin
         if (rem[b])
            rem = rem ^ (18'(BCH_POLY) << (b - 12));
      end
      return (18'(ver) << 12) | 18'(rem[11:0]);
   endfunction

   // flip n random bits (a bit may flip back, so the distance is at most n)
   function automatic logic [17:0] flip_bits(input logic [17:0] word, input int n);
      int k;
      for (k = 0; k < n; k++)
         word = word ^ (18'd1 << $urandom_range(0, 17));
      return word;
   endfunction

   function automatic req_type make_req(input int w, input int h,
                                        input logic [17:0] ll, input logic [17:0] ur);
      req_type it;
      it.sym_width        = 8'(w);
      it.sym_height       = 8'(h);
      it.lower_left_word  = ll;
      it.upper_right_word = ur;
      return it;
   endfunction

   function automatic req_type random_req();
      req_type    it;
      int         pick;
      int         ver;
      int         word_ver;
      logic [7:0] size;
      pick                = $urandom_range(0, 99);
      it.lower_left_word  = 18'($urandom);
      it.upper_right_word = 18'($urandom);
      if (pick < 65) begin
         // well-formed coded symbol, codewords with a few bit errors
         ver           = $urandom_range(7, 40);
         size          = 8'(17 + 4 * ver);
         it.sym_width  = size;
         it.sym_height = size;
         word_ver      = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 40) : ver;
         it.lower_left_word = flip_bits(bch_word(word_ver), $urandom_range(0, 5));
         case ($urandom_range(0, 2))
            0:       it.upper_right_word = flip_bits(bch_word(word_ver), $urandom_range(0, 5));
            1:       it.upper_right_word = flip_bits(bch_word($urandom_range(7, 40)),
                                                     $urandom_range(0, 5));
            default: ;
         endcase
      end else if (pick < 75) begin
         // small symbol, versions 1 to 6, words ignored
         size          = 8'(17 + 4 * $urandom_range(1, 6));
         it.sym_width  = size;
         it.sym_height = size;
      end else if (pick < 85) begin
         // near a legal size: off by a few modules or not square
         size          = 8'(17 + 4 * $urandom_range(1, 40));
         it.sym_width  = size + 8'($urandom_range(0, 6)) - 8'd3;
         it.sym_height = ($urandom_range(0, 1) == 0) ? it.sym_width : size;
         it.lower_left_word = flip_bits(bch_word($urandom_range(7, 40)), $urandom_range(0, 2));
      end else begin
         // raw noise over every field
         it.sym_width  = 8'($urandom);
         it.sym_height = ($urandom_range(0, 2) == 0) ? 8'($urandom) : it.sym_width;
      end
      return it;
   endfunction

   // present one item and hold it until an edge with busy low takes it
   task automatic send_item(input req_type it);
      req_item <= it;
      start    <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic idle_for(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // stop sending until every predicted result has come back
   task automatic drain_pipeline();
      start <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   initial begin : stimulus
      req_type directed [$];
      int      n_random;
      int      burst;
      int      k;
      int      wait_cycles;
      bit      paused;

      n_random = 0;
      paused   = 1'b0;

      // hold reset at the start, then release it
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // size extremes and illegal sizes
      directed.push_back(make_req(0, 0, 18'h00000, 18'h00000));
      directed.push_back(make_req(255, 255, 18'h3FFFF, 18'h3FFFF));
      directed.push_back(make_req(20, 20, bch_word(7), bch_word(7)));
      directed.push_back(make_req(21, 25, 18'h00000, 18'h00000));       // not square
      directed.push_back(make_req(23, 23, 18'h00000, 18'h00000));       // wrong mod 4
      directed.push_back(make_req(44, 44, bch_word(7), bch_word(7)));
      directed.push_back(make_req(176, 176, bch_word(40), bch_word(40)));
      directed.push_back(make_req(178, 178, bch_word(40), bch_word(40)));
      directed.push_back(make_req(181, 181, bch_word(41), bch_word(41))); // above the top
      directed.push_back(make_req(177, 173, bch_word(40), bch_word(39)));
      // small symbols ignore the words
      directed.push_back(make_req(21, 21, 18'h3FFFF, 18'h15555));
      directed.push_back(make_req(41, 41, 18'h2AAAA, 18'h00000));
      // exact matches at both ends of the coded range
      directed.push_back(make_req(45, 45, bch_word(7), 18'h00000));
      directed.push_back(make_req(177, 177, bch_word(40), bch_word(40)));
      // only the top-right word is readable
      directed.push_back(make_req(49, 49, 18'h3FFFF, bch_word(8)));
      // three errors still correct, four including the top two bits do not
      directed.push_back(make_req(49, 49, bch_word(8) ^ 18'h30001, 18'h3FFFF));
      directed.push_back(make_req(49, 49, bch_word(8) ^ 18'h30003, 18'h3FFFF));
      // uncorrectable at the smallest coded size and with all-ones words
      directed.push_back(make_req(45, 45, 18'h00000, 18'h00000));
      directed.push_back(make_req(177, 177, 18'h3FFFF, 18'h3FFFF));
      // decoded version disagrees with the size
      directed.push_back(make_req(45, 45, bch_word(20), bch_word(20)));
      // ties: lowest table entry wins over the other word
      directed.push_back(make_req(177, 177, bch_word(40), bch_word(7)));
      directed.push_back(make_req(137, 137, bch_word(30) ^ 18'h00010, bch_word(10) ^ 18'h20000));
      // same entry reached from both words at equal distance; then up to four flips beside a random word
      directed.push_back(make_req(65, 65, bch_word(12) ^ 18'h00003, bch_word(12) ^ 18'h30000));
      directed.push_back(make_req(173, 173, flip_bits(bch_word(39), 4), 18'($urandom)));

      foreach (directed[k]) begin
         send_item(directed[k]);
         if ($urandom_range(0, 3) == 0)
            idle_for($urandom_range(1, 4));
      end
      drain_pipeline();

      // random part in bursts; a zero gap lets bursts run together
      while (n_random < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 40);
         for (k = 0; k < burst && n_random < RANDOM_ITEMS; k++) begin
            send_item(random_req());
            n_random++;
         end
         if ($urandom_range(0, 3) != 0)
            idle_for($urandom_range(1, 12));
         // one full stop halfway through
         if (!paused && n_random >= RANDOM_ITEMS / 2) begin
            drain_pipeline();
            paused = 1'b1;
         end
      end

      // wait out the pipeline, bounded in case results stop coming
      start <= 1'b0;
      repeat (2) @(posedge clock);
      wait_cycles = 0;
      while (pending != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (pending != 0)
         $display("%0d predicted results never arrived", pending);
      $display("sent %0d items in random bursts with gaps and two full drains", items_sent);
      $display("results by status: %0d bad size, %0d ok, %0d uncorrectable, %0d disagreeing",
               bad_size_hits, ok_hits, uncorrectable_hits, disagree_hits);
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
